/* src/bssi_pkg.sv */
package bssi_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int VALUE_W  = 32;
   localparam int FUNC_W   = 2;
   localparam int STATUS_W = 2;
   localparam int FILL_W   = 5;

   // operation codes
   localparam logic [FUNC_W-1:0] OP_PUSH   = 2'd0;
   localparam logic [FUNC_W-1:0] OP_SORTED = 2'd1;
   localparam logic [FUNC_W-1:0] OP_POP    = 2'd2;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   localparam logic [VALUE_W-1:0] EMPTY_POP_VALUE = '1;

   typedef struct packed {
      logic [VALUE_W-1:0]  pop_value;
      logic [STATUS_W-1:0] status;
      logic [FILL_W-1:0]   fill_count;
   } result_type;

endpackage

/* src/bssi_mem.sv */
module bssi_mem
   import bssi_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [VALUE_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr,
   output logic [VALUE_W-1:0] rd_data
);

   logic [VALUE_W-1:0] mem [DEPTH];
   logic [VALUE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/bssi_ctrl.sv */
module bssi_ctrl
   import bssi_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   parameter int AW    = $clog2(DEPTH),
   parameter int CW    = $clog2(DEPTH + 1)
) (
   input  logic                clock,
   input  logic                reset,
   // command
   input  logic                cmd_valid,
   output logic                cmd_ready,
   input  logic [FUNC_W-1:0]   cmd_func,
   input  logic [VALUE_W-1:0]  cmd_value,
   // result
   output logic                res_valid,
   input  logic                res_take,
   output result_type          res,
   // stack memory
   output logic                wr_en,
   output logic [AW-1:0]       wr_addr,
   output logic [VALUE_W-1:0]  wr_data,
   output logic                rd_en,
   output logic [AW-1:0]       rd_addr,
   input  logic [VALUE_W-1:0]  rd_data
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_RD,
      S_CMP,
      S_INS,
      S_OUT
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       pos_ff, pos_in;
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [VALUE_W-1:0]  pop_ff, pop_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic                lifted;
   logic [CW-1:0]       count_dec;
   logic [31:0]         count_wide;

   // the shared compare unit: signed greater-than of stored entry against new value
   assign lifted = $signed(rd_data) > $signed(value_ff);

   assign count_dec  = count_ff - CW'(1);
   assign count_wide = 32'(count_ff);

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      pos_in    = pos_ff;
      value_in  = value_ff;
      pop_in    = pop_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      wr_addr   = count_ff[AW-1:0];
      wr_data   = value_ff;
      rd_en     = 1'b0;
      rd_addr   = count_dec[AW-1:0];

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               value_in  = cmd_value;
               pop_in    = '0;
               status_in = ST_DONE;
               state_in  = S_OUT;
               if (cmd_func == OP_PUSH || cmd_func == OP_SORTED) begin
                  if (count_ff == CW'(DEPTH)) begin
                     status_in = ST_FULL;
                  end else if (cmd_func == OP_PUSH || count_ff == '0) begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[AW-1:0];
                     wr_data  = cmd_value;
                     count_in = count_ff + CW'(1);
                  end else begin
                     // walk down from the top, one entry per compare
                     pos_in   = count_ff[AW-1:0];
                     rd_en    = 1'b1;
                     rd_addr  = count_dec[AW-1:0];
                     state_in = S_CMP;
                  end
               end else if (cmd_func == OP_POP) begin
                  if (count_ff == '0) begin
                     status_in = ST_EMPTY;
                     pop_in    = EMPTY_POP_VALUE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_addr  = count_dec[AW-1:0];
                     count_in = count_dec;
                     state_in = S_POP_RD;
                  end
               end
            end
         end
         S_POP_RD: begin
            pop_in   = rd_data;
            state_in = S_OUT;
         end
         S_CMP: begin
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            if (lifted) begin
               // move entry up one slot
               wr_data = rd_data;
               pos_in  = pos_ff - AW'(1);
               if (pos_ff == AW'(1)) begin
                  state_in = S_INS;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = pos_ff - AW'(1) - AW'(1);
               end
            end else begin
               wr_data  = value_ff;
               count_in = count_ff + CW'(1);
               state_in = S_OUT;
            end
         end
         S_INS: begin
            wr_en    = 1'b1;
            wr_addr  = pos_ff;
            wr_data  = value_ff;
            count_in = count_ff + CW'(1);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      pos_ff    <= pos_in;
      value_ff  <= value_in;
      pop_ff    <= pop_in;
      status_ff <= status_in;
   end

   assign cmd_ready      = (state_ff == S_IDLE);
   assign res_valid      = (state_ff == S_OUT);
   assign res.pop_value  = pop_ff;
   assign res.status     = status_ff;
   assign res.fill_count = count_wide[FILL_W-1:0];

endmodule

/* src/bounded_stack_sorted_insert_top.sv */
// bounded stack with plain push, sorted push and pop, one word in, one word out
// push, refused push/pop, unused code and sorted push on an empty stack go straight
//   to the result state; pop first reads the top entry, and a sorted push on a
//   non-empty stack compares down one entry at a time until its slot is found
// one word at a time: the next word is taken only after the last result has moved
//   into the output register; the stack ram read port and the shared entry comparator
//   set the one-cycle-per-entry step of a sorted push
// reset: synchronous, active high; clears the entry count and handshake state,
//   stack ram contents are not cleared
module bounded_stack_sorted_insert_top
   import bssi_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // func [1:0], value [33:2], zero [39:34]
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // pop_value [31:0], status [33:32],
                                    // fill_count [38:34], zero [39]
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   // memory port
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [VALUE_W-1:0] wr_data;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [VALUE_W-1:0] rd_data;

   // sequencer result side
   logic               res_valid;
   logic               res_take;
   result_type         res;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_ff, rsp_in;

   bssi_mem #(
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   bssi_ctrl #(
      .DEPTH (DEPTH),
      .AW    (AW),
      .CW    (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_tvalid),
      .cmd_ready (req_tready),
      .cmd_func  (req_tdata[1:0]),
      .cmd_value (req_tdata[33:2]),
      .res_valid (res_valid),
      .res_take  (res_take),
      .res       (res),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data)
   );

   // result moves in when the register is empty or being drained this cycle
   assign res_take = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_take) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff.fill_count, rsp_ff.status, rsp_ff.pop_value};

endmodule

/* tb/stack_result_checker.sv */
module stack_result_checker
   import bssi_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [39:0] req_tdata,   // func [1:0], value [33:2], zero [39:34]
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // pop_value [31:0], status [33:32],
                                    // fill_count [38:34], zero [39]
   output int          error_count,
   output int          words_outstanding
);

   logic signed [VALUE_W-1:0] held_values [DEPTH];
   int unsigned               held_count = 0;
   result_type                expected_results [$];
   int                        errors_seen = 0;

   // one operation on the shadow stack, returns the word the block must answer
   function automatic result_type stack_step(input logic [FUNC_W-1:0] func,
                                             input logic signed [VALUE_W-1:0] value);
      result_type  res;
      int unsigned slot;
      res.pop_value = '0;
      res.status    = ST_DONE;
      if (func == OP_PUSH || func == OP_SORTED) begin
         if (held_count >= DEPTH) begin
            res.status = ST_FULL;
         end else begin
            slot = held_count;
            // lift every greater entry off the top, equal ones stay below
            if (func == OP_SORTED) begin
               while (slot > 0 && held_values[slot-1] > value) begin
                  held_values[slot] = held_values[slot-1];
                  slot--;
               end
            end
            held_values[slot] = value;
            held_count++;
         end
      end else if (func == OP_POP) begin
         if (held_count == 0) begin
            res.status    = ST_EMPTY;
            res.pop_value = EMPTY_POP_VALUE;
         end else begin
            held_count--;
            res.pop_value = held_values[held_count];
         end
      end
      res.fill_count = held_count[FILL_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin : watch_edge
      result_type got;
      result_type want;
      if (reset) begin
         expected_results.delete();
         held_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.pop_value  = rsp_tdata[31:0];
            got.status     = rsp_tdata[33:32];
            got.fill_count = rsp_tdata[38:34];
            if (expected_results.size() == 0) begin
               $error("response word %h with no request waiting", rsp_tdata);
               errors_seen++;
            end else begin
               want = expected_results.pop_front();
               if (got.pop_value !== want.pop_value) begin
                  $error("pop_value: expected %0d, actual %0d",
                         $signed(want.pop_value), $signed(got.pop_value));
                  errors_seen++;
               end
               if (got.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, got.status);
                  errors_seen++;
               end
               if (got.fill_count !== want.fill_count) begin
                  $error("fill_count: expected %0d, actual %0d",
                         want.fill_count, got.fill_count);
                  errors_seen++;
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_results.push_back(stack_step(req_tdata[1:0], req_tdata[33:2]));
      end
      error_count       <= errors_seen;
      words_outstanding <= expected_results.size();
   end

endmodule

/* tb/tb_bounded_stack_sorted_insert_top.sv */
module tb_bounded_stack_sorted_insert_top;
   import bssi_pkg::*;

   // func 3 has no meaning, the block must answer it without touching the stack
   localparam logic [FUNC_W-1:0] OP_UNUSED = 2'd3;

   localparam int RANDOM_WORDS = 1000;
   // receiver hold-off window, long enough for the block to stall its input
   localparam int HOLD_START   = 600;
   localparam int HOLD_CYCLES  = 300;
   // window where neither side idles
   localparam int QUIET_FROM   = 2000;
   localparam int QUIET_TO     = 3500;
   // worst sorted push lifts DEPTH - 1 entries, leave margin after the last word
   localparam int TAIL_CYCLES  = 3 * DEPTH_DEFAULT + 16;

   // which way the random stream leans, so full and empty are both reached often
   typedef enum {LEAN_FILL, LEAN_DRAIN, LEAN_MIXED} lean_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;    // func [1:0], value [33:2], zero [39:34]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // pop_value [31:0], status [33:32],
                              // fill_count [38:34], zero [39]

   int   error_count;
   int   words_outstanding;
   int   cycle_no = 0;
   logic quiet;

   bounded_stack_sorted_insert_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // shadow stack and comparison live in the checker, it only watches the channels
   stack_result_checker #(
      .DEPTH (DEPTH_DEFAULT)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .error_count       (error_count),
      .words_outstanding (words_outstanding)
   );

   // 2 time unit period, rising edge at odd times
   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   always @(posedge clock) begin
      cycle_no <= cycle_no + 1;
   end

   assign quiet = (cycle_no >= QUIET_FROM) && (cycle_no < QUIET_TO);

   // hard stop, far beyond the slowest legal run
   initial begin
      #1000000;
      $display("*** FAILED ***");
      $finish;
   end

   // response side: random back-pressure, one long hold-off, none in the quiet window
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (cycle_no == HOLD_START) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_tready <= quiet || ($urandom_range(99) >= 11);
      end
   end

   // offer one word and hold it until the block takes it
   task automatic send_word(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] value);
      if (!quiet && $urandom_range(99) < 11) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'd0, value, func};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // values: a narrow band around zero so sorted pushes see ties, the extremes,
   // and fully random patterns
   function automatic logic [VALUE_W-1:0] pick_value();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 40)
         return VALUE_W'(int'($urandom_range(16)) - 8);
      if (roll < 50) begin
         case ($urandom_range(3))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            default: return 32'hffff_ffff;
         endcase
      end
      return $urandom();
   endfunction

   function automatic logic [FUNC_W-1:0] pick_func(input lean_type lean);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 3)
         return OP_UNUSED;
      case (lean)
         LEAN_FILL:  return (roll < 50) ? OP_PUSH : (roll < 88) ? OP_SORTED : OP_POP;
         LEAN_DRAIN: return (roll < 14) ? OP_PUSH : (roll < 25) ? OP_SORTED : OP_POP;
         default:    return (roll < 35) ? OP_PUSH : (roll < 67) ? OP_SORTED : OP_POP;
      endcase
   endfunction

   initial begin
      lean_type lean;
      int       run_left;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      lean       = LEAN_FILL;
      run_left   = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: empty pop and unused code on an empty stack
      send_word(OP_POP, 32'h1234_5678);
      send_word(OP_UNUSED, 32'h0000_0000);
      // extremes, sorted push that lifts the whole stack, ties that stay below
      send_word(OP_PUSH, 32'h7fff_ffff);
      send_word(OP_SORTED, 32'h8000_0000);
      send_word(OP_SORTED, 32'h0000_0000);
      send_word(OP_SORTED, 32'h0000_0000);
      send_word(OP_SORTED, 32'hffff_ffff);
      send_word(OP_POP, 32'hffff_ffff);
      send_word(OP_UNUSED, 32'hffff_ffff);
      // fill to the top with alternating bit patterns, sorted ones land on the smaller top entry
      for (int i = 0; i < DEPTH_DEFAULT - 4; i++) begin
         if (i % 2 == 0)
            send_word(OP_PUSH, 32'haaaa_aaaa);
         else
            send_word(OP_SORTED, 32'h5555_5555);
      end
      // both push kinds on a full stack are refused, then unused code and a pop
      send_word(OP_PUSH, 32'h0000_0001);
      send_word(OP_SORTED, 32'h8000_0000);
      send_word(OP_UNUSED, 32'h7fff_ffff);
      send_word(OP_POP, 32'h0000_0000);

      // sender pause: let every outstanding response drain before going random
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (words_outstanding != 0) @(posedge clock);

      // random: runs that lean toward filling or draining, so the stack keeps
      // crossing between empty and full with random contents
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(10, 40);
            case ($urandom_range(2))
               0:       lean = LEAN_FILL;
               1:       lean = LEAN_DRAIN;
               default: lean = LEAN_MIXED;
            endcase
         end
         run_left--;
         send_word(pick_func(lean), pick_value());
      end
      req_tvalid <= 1'b0;

      // wait for the last responses, then a margin for stray words
      @(posedge clock);
      while (words_outstanding != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0 && words_outstanding == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
